// ----- hdl/alrg_pkg.sv -----
// ----------------------------------------------------------------------------
// alrg_pkg
// Types and constants shared by the additive lagged random generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alrg_pkg;

  localparam int unsigned WordW    = 16;
  localparam int unsigned TableLen = 55;
  localparam int unsigned TrailTap = 31;
  localparam int unsigned CntW     = $clog2(TableLen);

  localparam logic [WordW-1:0] LcgMul    = 16'd25173;
  localparam logic [WordW-1:0] LcgAdd    = 16'd13849;
  localparam logic [WordW-1:0] SeedReset = 16'd42;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    OP_INIT = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef enum logic {
    FILL_IDLE = 1'b0,
    FILL_RUN  = 1'b1
  } fill_state_e;

  typedef struct packed {
    logic shift;
    logic dir_up;
  } cell_ctrl_t;

endpackage

// ----- hdl/alrg_cell.sv -----
// ----------------------------------------------------------------------------
// alrg_cell
// One word of the lag table; shifts toward either neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alrg_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alrg_pkg::cell_ctrl_t ctrl_i,
  input  alrg_pkg::word_t    lower_i,
  input  alrg_pkg::word_t    upper_i,
  output alrg_pkg::word_t    word_o
);
  import alrg_pkg::*;

  word_t word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift) begin
      word_d = ctrl_i.dir_up ? lower_i : upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ----- hdl/alrg_filler.sv -----
// ----------------------------------------------------------------------------
// alrg_filler
// Congruential generator and sequencer that reloads the lag table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alrg_filler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  alrg_pkg::word_t seed_i,
  output logic            busy_o,
  output logic            shift_o,
  output alrg_pkg::word_t word_o
);
  import alrg_pkg::*;

  fill_state_e state_d, state_q;
  word_t       lcg_d, lcg_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  word_t       lcg_next;

  assign lcg_next = word_t'(lcg_q * LcgMul) + LcgAdd;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FILL_IDLE: if (start_i) state_d = FILL_RUN;
      FILL_RUN:  if (cnt_q == '0) state_d = FILL_IDLE;
      default:   state_d = FILL_IDLE;
    endcase
  end

  always_comb begin
    busy_o  = 1'b0;
    shift_o = 1'b0;
    lcg_d   = lcg_q;
    cnt_d   = cnt_q;
    case (state_q)
      FILL_IDLE: begin
        if (start_i) begin
          lcg_d = seed_i;
          cnt_d = CntW'(TableLen - 1);
        end
      end
      FILL_RUN: begin
        busy_o  = 1'b1;
        shift_o = 1'b1;
        lcg_d   = lcg_next;
        cnt_d   = cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL_IDLE;
      lcg_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lcg_q   <= lcg_d;
      cnt_q   <= cnt_d;
    end
  end

  assign word_o = lcg_next;

endmodule

// ----- hdl/additive_lagged_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// additive_lagged_random_generator_unit
// Additive lagged random generator, lags 55 and 24, on a row of word cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | op_i, range_limit_i
//  out     | output    | out_valid_o/out_stall_i| raw_value_o, scaled_value_o
//  seed    | input     | seed_we_i              | seed_wdata_i
//
//  A draw's result is registered; draws stream at one per clock while out is
//  taken and no fill runs. An init loads the seed, then shifts 55 generator
//  words into the cell row, one multiply per cycle; in_stall_o stays high.
//  Reset clears all cells, restores seed 42 and the generator state.
//  A stalled result holds in the output reg; in stalls if full or filling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module additive_lagged_random_generator_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [alrg_pkg::WordW-1:0] range_limit_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [alrg_pkg::WordW-1:0] raw_value_o,
  output logic [alrg_pkg::WordW-1:0] scaled_value_o,
  input  logic                    seed_we_i,
  input  logic [alrg_pkg::WordW-1:0] seed_wdata_i
);
  import alrg_pkg::*;

  word_t      seed_q;
  word_t      cell_w [TableLen];
  cell_ctrl_t cell_ctrl;
  logic       fill_busy, fill_shift;
  word_t      fill_word;
  logic       slot_free, in_acc, draw_acc, init_acc;
  word_t      sum;
  logic       out_valid_d, out_valid_q;
  word_t      raw_d, raw_q, range_d, range_q;
  logic [2*WordW-1:0] product;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = fill_busy || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign draw_acc   = in_acc && (op_i == OP_DRAW);
  assign init_acc   = in_acc && (op_i == OP_INIT);

  assign sum = cell_w[0] + cell_w[TrailTap];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  alrg_filler u_filler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (init_acc),
    .seed_i  (seed_q),
    .busy_o  (fill_busy),
    .shift_o (fill_shift),
    .word_o  (fill_word)
  );

  // Fill shifts up from cell 0, a draw shifts down and enters at the top.
  assign cell_ctrl.shift  = fill_shift || draw_acc;
  assign cell_ctrl.dir_up = fill_shift;

  for (genvar k = 0; k < TableLen; k++) begin : g_cell
    word_t lower, upper;
    if (k == 0) begin : g_bottom
      assign lower = fill_word;
    end else begin : g_lower
      assign lower = cell_w[k-1];
    end
    if (k == TableLen - 1) begin : g_top
      assign upper = sum;
    end else begin : g_upper
      assign upper = cell_w[k+1];
    end
    alrg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_w[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    raw_d       = raw_q;
    range_d     = range_q;
    if (draw_acc) begin
      out_valid_d = 1'b1;
      raw_d       = sum;
      range_d     = range_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    range_q <= range_d;
  end

  assign product        = {{WordW{1'b0}}, raw_q} * {{WordW{1'b0}}, range_q};
  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_q;
  assign scaled_value_o = product[2*WordW-1:WordW];

  a_no_accept_while_filling : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> !in_acc)
    else $error("transaction accepted during table fill");

  a_init_starts_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_acc |=> fill_busy)
    else $error("init transaction did not start table fill");

  a_draw_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> (out_valid_o && raw_value_o == $past(sum)))
    else $error("draw result lost or wrong");

  a_fill_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_busy && !out_valid_o) |=> !out_valid_o)
    else $error("result produced during table fill");

endmodule

// ----- tb/additive_lagged_random_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// additive_lagged_random_generator_unit_tb
// Checks every draw of the lag-55/24 additive generator against a behavioral
// model of the lag table. A directed table comes first: draws on the cleared
// table, reloads, and range extremes. Random phases follow, each under a new
// seed and each led by a reload. Both handshakes idle at random, and one long
// output hold-off makes the input stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module additive_lagged_random_generator_unit_tb;
  import alrg_pkg::*;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseItems    = 256;
  localparam int unsigned SettleCycles  = 70;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned NumDirected   = 16;

  typedef struct packed {
    word_t raw;
    word_t scaled;
  } draw_result_t;

  typedef struct packed {
    op_e   op;
    word_t range_limit;
    logic  typed;
    word_t raw;
    word_t scaled;
  } stim_row_t;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  in_valid_i     = 1'b0;
  logic  in_stall_o;
  logic  op_i           = 1'b0;
  word_t range_limit_i  = '0;
  logic  out_valid_o;
  logic  out_stall_i    = 1'b0;
  word_t raw_value_o;
  word_t scaled_value_o;
  logic  seed_we_i      = 1'b0;
  word_t seed_wdata_i   = '0;

  word_t        lag_words [TableLen];
  int unsigned  lead_pos;
  int unsigned  trail_pos;
  word_t        seed_reg;
  draw_result_t pending_draws [$];

  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned draws_sent      = 0;
  int unsigned reloads_sent    = 0;
  int unsigned seeds_loaded    = 0;
  int unsigned calm_left       = 0;
  bit          hold_off_req    = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{OP_DRAW, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h0001, 1'b1, 16'h0000, 16'h0000},
    '{OP_INIT, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{OP_INIT, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{OP_INIT, 16'h1234, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 16'hFFFF, 1'b0, 16'h0000, 16'h0000}
  };

  additive_lagged_random_generator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .range_limit_i (range_limit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .raw_value_o   (raw_value_o),
    .scaled_value_o(scaled_value_o),
    .seed_we_i     (seed_we_i),
    .seed_wdata_i  (seed_wdata_i)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic void clear_lag_table();
    for (int i = 0; i < TableLen; i++) begin
      lag_words[i] = '0;
    end
    lead_pos  = TableLen - 1;
    trail_pos = 23;
    seed_reg  = SeedReset;
  endfunction

  function automatic void reload_lag_table();
    word_t lcg;
    lcg = seed_reg;
    for (int i = 0; i < TableLen; i++) begin
      lcg = word_t'(lcg * LcgMul + LcgAdd);
      lag_words[i] = lcg;
    end
    lead_pos  = TableLen - 1;
    trail_pos = 23;
  endfunction

  function automatic draw_result_t draw_next(word_t rng);
    draw_result_t res;
    logic [2*WordW-1:0] product;
    res.raw = word_t'(lag_words[lead_pos] + lag_words[trail_pos]);
    lag_words[lead_pos] = res.raw;
    product = res.raw * rng;
    res.scaled = product[2*WordW-1:WordW];
    lead_pos  = (lead_pos == 0) ? TableLen - 1 : lead_pos - 1;
    trail_pos = (trail_pos == 0) ? TableLen - 1 : trail_pos - 1;
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic word_t random_range_limit();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    if (roll == 2) return word_t'($urandom_range(16, 1));
    return word_t'($urandom_range(16'hFFFF));
  endfunction

  task automatic send_item(op_e op, word_t rng, logic typed, word_t t_raw, word_t t_scaled);
    int unsigned  gap;
    draw_result_t predicted;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(15) == 0) begin
      calm_left = $urandom_range(60, 20);
      gap = 0;
    end else begin
      gap = gap_len();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    range_limit_i <= rng;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_INIT) begin
      reload_lag_table();
      reloads_sent++;
    end else begin
      predicted = draw_next(rng);
      if (typed) begin
        predicted.raw    = t_raw;
        predicted.scaled = t_scaled;
      end
      pending_draws.push_back(predicted);
      draws_sent++;
    end
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic load_seed(word_t value);
    wait (pending_draws.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
    seed_we_i    <= 1'b1;
    seed_wdata_i <= value;
    @(negedge clk_i);
    seed_we_i <= 1'b0;
    seed_reg = value;
    seeds_loaded++;
  endtask

  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected transaction: raw_value %h scaled_value %h",
               raw_value_o, scaled_value_o);
        mismatch_count++;
      end else begin
        want = pending_draws.pop_front();
        results_checked++;
        if (raw_value_o !== want.raw) begin
          $error("raw_value: expected %h, got %h", want.raw, raw_value_o);
          mismatch_count++;
        end
        if (scaled_value_o !== want.scaled) begin
          $error("scaled_value: expected %h, got %h", want.scaled, scaled_value_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned quiet_left;
    int unsigned gap;
    logic        stall;
    hold_left  = 0;
    stall_left = 0;
    quiet_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles - 1;
        stall        = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        stall = 1'b0;
      end else if ($urandom_range(15) == 0) begin
        quiet_left = $urandom_range(80, 20);
        stall      = 1'b0;
      end else begin
        gap = gap_len();
        stall_left = (gap > 0) ? gap - 1 : 0;
        stall = (gap > 0);
      end
      out_stall_i <= stall;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("additive_lagged_random_generator_unit_tb failed");
    $finish;
  end

  initial begin
    word_t phase_seeds [NumPhases];
    op_e   op;
    clear_lag_table();
    phase_seeds[0] = 16'h0000;
    phase_seeds[1] = 16'hFFFF;
    phase_seeds[2] = SeedReset;
    for (int p = 3; p < NumPhases; p++) begin
      phase_seeds[p] = word_t'($urandom_range(16'hFFFF));
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumDirected; r++) begin
      send_item(directed_rows[r].op, directed_rows[r].range_limit, directed_rows[r].typed,
                directed_rows[r].raw, directed_rows[r].scaled);
    end
    release_input();

    for (int p = 0; p < NumPhases; p++) begin
      load_seed(phase_seeds[p]);
      if (p == 2) hold_off_req = 1'b1;
      send_item(OP_INIT, random_range_limit(), 1'b0, '0, '0);
      for (int i = 1; i < PhaseItems; i++) begin
        op = ($urandom_range(79) == 0) ? OP_INIT : OP_DRAW;
        send_item(op, random_range_limit(), 1'b0, '0, '0);
      end
      release_input();
    end

    wait (pending_draws.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d draws and %0d table reloads under %0d seed loads;",
             draws_sent, reloads_sent, seeds_loaded);
    $display("checked %0d results with %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("additive_lagged_random_generator_unit_tb passed");
    end else begin
      $display("additive_lagged_random_generator_unit_tb failed");
    end
    $finish;
  end

endmodule
